// ===== design/tssu_pkg.sv =====
// Shared types, constants and coil table for the three-axis stepper sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tssu_pkg;

   // field widths fixed by the item format
   localparam int STEPS_W    = 32;
   localparam int INTERVAL_W = 24;
   localparam int COIL_W     = 4;
   localparam int PHASE_W    = 3;
   localparam int CMD_W      = 2;
   localparam int PORT_AXES  = 3;

   // parameter defaults
   localparam int AXES_DEFAULT           = 3;
   localparam int PHASE_COUNT_DEFAULT    = 8;
   localparam int POSITION_WIDTH_DEFAULT = 48;

   localparam logic [INTERVAL_W-1:0] HOME_INTERVAL_RESET = INTERVAL_W'(3000);

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOME = 2'd2;

   // saturation limits of a home step count
   localparam logic [STEPS_W-1:0] STEPS_MAX = 32'h7FFF_FFFF;
   localparam logic [STEPS_W-1:0] STEPS_MIN = 32'h8000_0000;

   // two-coils-on full-step pattern, one row per phase modulo 4
   localparam logic [COIL_W-1:0] COIL_ROWS [4] = '{4'b0011, 4'b0110, 4'b1100, 4'b1001};

   typedef struct packed {
      logic tick;
      logic start;
   } lane_ctrl_type;

   typedef struct packed {
      logic              active_ff;
      logic              active_in;
      logic [COIL_W-1:0] coils_in;
   } lane_status_type;

   function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
      coil_pattern = COIL_ROWS[phase[1:0]];
   endfunction

endpackage

`default_nettype wire

// ===== design/tssu_axis_lane.sv =====
// One axis lane: phase stepper, step counter and interval timer of one motor.
// Depends on tssu_pkg.
`default_nettype none

module tssu_axis_lane #(
   parameter int PHASE_COUNT = tssu_pkg::PHASE_COUNT_DEFAULT
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire tssu_pkg::lane_ctrl_type             ctrl,
   input  wire logic [tssu_pkg::STEPS_W-1:0]        start_steps,
   input  wire logic [tssu_pkg::INTERVAL_W-1:0]     start_interval,
   output tssu_pkg::lane_status_type                status
);
   import tssu_pkg::*;

   localparam logic [PHASE_W:0]   PHASE_LIMIT = (PHASE_W+1)'(PHASE_COUNT);
   localparam logic [PHASE_W-1:0] PHASE_TOP   = PHASE_W'(PHASE_COUNT - 1);

   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [STEPS_W-1:0]    steps_left_ff, steps_left_in;
   logic                  step_down_ff, step_down_in;
   logic [INTERVAL_W-1:0] timer_ff, timer_in;
   logic [INTERVAL_W-1:0] load_ff, load_in;
   logic                  active_ff, active_in;
   logic [COIL_W-1:0]     coils_ff, coils_in;

   logic                  start_neg;
   logic                  dir;
   logic [PHASE_W:0]      phase_up;
   logic [PHASE_W-1:0]    phase_step;
   logic [INTERVAL_W-1:0] interval_fix;
   logic [INTERVAL_W-1:0] timer_dec;

   assign start_neg    = start_steps[STEPS_W-1];
   assign dir          = ctrl.start ? start_neg : step_down_ff;
   assign phase_up     = {1'b0, phase_ff} + (PHASE_W+1)'(1);
   assign interval_fix = (start_interval == '0) ? INTERVAL_W'(1) : start_interval;
   assign timer_dec    = (timer_ff != '0) ? timer_ff - INTERVAL_W'(1) : '0;

   // next phase for one step in the chosen direction
   always_comb begin
      if (dir) begin
         if (phase_ff == '0 || {1'b0, phase_ff} >= PHASE_LIMIT) begin
            phase_step = PHASE_TOP;
         end else begin
            phase_step = phase_ff - PHASE_W'(1);
         end
      end else begin
         if (phase_up >= PHASE_LIMIT) begin
            phase_step = '0;
         end else begin
            phase_step = phase_up[PHASE_W-1:0];
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      steps_left_in = steps_left_ff;
      step_down_in  = step_down_ff;
      timer_in      = timer_ff;
      load_in       = load_ff;
      active_in     = active_ff;
      coils_in      = coils_ff;
      if (ctrl.start) begin
         step_down_in = start_neg;
         load_in      = interval_fix;
         if (start_steps == '0) begin
            coils_in      = '0;
            active_in     = 1'b0;
            steps_left_in = '0;
            timer_in      = '0;
         end else begin
            phase_in      = phase_step;
            coils_in      = coil_pattern(phase_step);
            // count minus one: ~s for a negative count, s - 1 otherwise
            steps_left_in = start_neg ? ~start_steps : start_steps - STEPS_W'(1);
            timer_in      = interval_fix;
            active_in     = 1'b1;
         end
      end else if (ctrl.tick && active_ff) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (steps_left_ff != '0) begin
               phase_in      = phase_step;
               coils_in      = coil_pattern(phase_step);
               steps_left_in = steps_left_ff - STEPS_W'(1);
               timer_in      = load_ff;
            end else begin
               coils_in  = '0;
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         steps_left_ff <= '0;
         step_down_ff  <= 1'b0;
         timer_ff      <= '0;
         load_ff       <= '0;
         active_ff     <= 1'b0;
         coils_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         steps_left_ff <= steps_left_in;
         step_down_ff  <= step_down_in;
         timer_ff      <= timer_in;
         load_ff       <= load_in;
         active_ff     <= active_in;
         coils_ff      <= coils_in;
      end
   end

   assign status.active_ff = active_ff;
   assign status.active_in = active_in;
   assign status.coils_in  = coils_in;

endmodule

`default_nettype wire

// ===== design/tssu_position.sv =====
// Step position tracker of one axis, with the registered home step count.
// Depends on tssu_pkg.
`default_nettype none

module tssu_position #(
   parameter int POSITION_WIDTH = tssu_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire logic [tssu_pkg::STEPS_W-1:0]   start_steps,
   output logic signed [POSITION_WIDTH-1:0]    position_in,
   output logic [tssu_pkg::STEPS_W-1:0]        home_steps
);
   import tssu_pkg::*;

   logic signed [POSITION_WIDTH-1:0] position_ff;
   logic [STEPS_W-1:0]               home_steps_ff, home_steps_in;
   logic [POSITION_WIDTH-1:0]        back;
   logic [POSITION_WIDTH-STEPS_W:0]  back_top;
   logic [POSITION_WIDTH-1:0]        steps_ext;

   assign steps_ext   = {{(POSITION_WIDTH-STEPS_W){start_steps[STEPS_W-1]}}, start_steps};
   assign position_in = start ? position_ff + $signed(steps_ext) : position_ff;

   // negated position, saturated into the 32-bit step range
   assign back     = '0 - position_ff;
   assign back_top = back[POSITION_WIDTH-1:STEPS_W-1];

   always_comb begin
      if ((&back_top) || !(|back_top)) begin
         home_steps_in = back[STEPS_W-1:0];
      end else begin
         home_steps_in = back[POSITION_WIDTH-1] ? STEPS_MIN : STEPS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         home_steps_ff <= '0;
      end else begin
         position_ff   <= position_in;
         home_steps_ff <= home_steps_in;
      end
   end

   assign home_steps = home_steps_ff;

endmodule

`default_nettype wire

// ===== design/three_axis_stepper_sequencer_unit.sv =====
// Throughput: one item per clock while req_stall is low; each accepted item updates
// every lane, and its result is registered in the output register or the skid entry.
// A two-entry output buffer (output register plus skid) keeps input flowing while
// a result waits; req_stall rises only when both entries hold results.
// Reset (synchronous, active high): all axes idle, coils off, positions zero,
// home interval 3000 ticks, output buffer empty.
`default_nettype none

module three_axis_stepper_sequencer_unit #(
   parameter int AXES           = tssu_pkg::AXES_DEFAULT,
   parameter int PHASE_COUNT    = tssu_pkg::PHASE_COUNT_DEFAULT,
   parameter int POSITION_WIDTH = tssu_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // input channel
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire logic [tssu_pkg::CMD_W-1:0]        req_command,
   input  wire logic signed [tssu_pkg::STEPS_W-1:0] req_steps_a,
   input  wire logic signed [tssu_pkg::STEPS_W-1:0] req_steps_b,
   input  wire logic signed [tssu_pkg::STEPS_W-1:0] req_steps_c,
   input  wire logic [tssu_pkg::INTERVAL_W-1:0]   req_interval_a,
   input  wire logic [tssu_pkg::INTERVAL_W-1:0]   req_interval_b,
   input  wire logic [tssu_pkg::INTERVAL_W-1:0]   req_interval_c,
   // result channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [tssu_pkg::COIL_W-1:0]            rsp_coils_a,
   output logic [tssu_pkg::COIL_W-1:0]            rsp_coils_b,
   output logic [tssu_pkg::COIL_W-1:0]            rsp_coils_c,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_rejected,
   output logic signed [POSITION_WIDTH-1:0]       rsp_position_a,
   output logic signed [POSITION_WIDTH-1:0]       rsp_position_b,
   // configuration write channel
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tssu_pkg::INTERVAL_W-1:0]   csr_home_interval
);
   import tssu_pkg::*;

   // only the first three axes can ever be commanded; positions exist for a and b
   localparam int LANES    = (AXES < PORT_AXES) ? AXES : PORT_AXES;
   localparam int POS_AXES = (LANES < 2) ? LANES : 2;

   typedef struct packed {
      logic [COIL_W-1:0]                coils_a;
      logic [COIL_W-1:0]                coils_b;
      logic [COIL_W-1:0]                coils_c;
      logic                             busy;
      logic                             rejected;
      logic signed [POSITION_WIDTH-1:0] position_a;
      logic signed [POSITION_WIDTH-1:0] position_b;
   } result_type;

   // configuration register
   logic [INTERVAL_W-1:0] home_interval_ff, home_interval_in;

   // handshake and command decode
   logic          accept;
   logic          is_motion;
   logic          busy_now;
   logic          busy_next;
   logic          start_go;
   lane_ctrl_type lane_ctrl;

   // per-axis start data and lane results
   logic [STEPS_W-1:0]               req_steps_arr  [PORT_AXES];
   logic [INTERVAL_W-1:0]            req_iv_arr     [PORT_AXES];
   logic [STEPS_W-1:0]               start_steps    [PORT_AXES];
   logic [INTERVAL_W-1:0]            start_iv       [PORT_AXES];
   logic [STEPS_W-1:0]               home_steps     [PORT_AXES];
   lane_status_type                  lane_status    [PORT_AXES];
   logic signed [POSITION_WIDTH-1:0] position_next  [2];

   // output buffer
   result_type result_new;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       take;

   // ---------------------------------------------------------------
   // Configuration: always ready, the block is idle by contract.
   // ---------------------------------------------------------------
   assign csr_ready        = 1'b1;
   assign home_interval_in = (csr_valid && csr_ready) ? csr_home_interval : home_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         home_interval_ff <= HOME_INTERVAL_RESET;
      end else begin
         home_interval_ff <= home_interval_in;
      end
   end

   // ---------------------------------------------------------------
   // Command decode. A move or home transfer while any lane is active
   // is dropped and flagged as rejected.
   // ---------------------------------------------------------------
   assign accept    = req_valid && !req_stall;
   assign is_motion = req_command inside {CMD_MOVE, CMD_HOME};
   assign start_go  = accept && is_motion && !busy_now;

   assign lane_ctrl.tick  = accept && (req_command == CMD_TICK);
   assign lane_ctrl.start = start_go;

   assign req_steps_arr[0] = req_steps_a;
   assign req_steps_arr[1] = req_steps_b;
   assign req_steps_arr[2] = req_steps_c;
   assign req_iv_arr[0]    = req_interval_a;
   assign req_iv_arr[1]    = req_interval_b;
   assign req_iv_arr[2]    = req_interval_c;

   // Home: a and b run back by their saturated negated positions at the
   // configured interval, c gets a zero count.
   always_comb begin
      for (int k = 0; k < PORT_AXES; k++) begin
         if (req_command == CMD_HOME) begin
            start_steps[k] = home_steps[k];
            start_iv[k]    = home_interval_ff;
         end else begin
            start_steps[k] = req_steps_arr[k];
            start_iv[k]    = req_iv_arr[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Lanes, one per axis, and position trackers for axes a and b.
   // ---------------------------------------------------------------
   for (genvar k = 0; k < PORT_AXES; k++) begin : g_lane
      if (k < LANES) begin : g_live
         tssu_axis_lane #(
            .PHASE_COUNT    (PHASE_COUNT)
         ) u_lane (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (lane_ctrl),
            .start_steps    (start_steps[k]),
            .start_interval (start_iv[k]),
            .status         (lane_status[k])
         );
      end else begin : g_absent
         assign lane_status[k] = '0;
      end
   end

   for (genvar k = 0; k < 2; k++) begin : g_pos
      if (k < POS_AXES) begin : g_live
         tssu_position #(
            .POSITION_WIDTH (POSITION_WIDTH)
         ) u_position (
            .clock          (clock),
            .reset          (reset),
            .start          (start_go),
            .start_steps    (start_steps[k]),
            .position_in    (position_next[k]),
            .home_steps     (home_steps[k])
         );
      end else begin : g_absent
         assign position_next[k] = '0;
         assign home_steps[k]    = '0;
      end
   end

   assign home_steps[2] = '0;

   // ---------------------------------------------------------------
   // Merge: busy before and after the item, and the result record.
   // ---------------------------------------------------------------
   always_comb begin
      busy_now  = 1'b0;
      busy_next = 1'b0;
      for (int k = 0; k < PORT_AXES; k++) begin
         busy_now  = busy_now  | lane_status[k].active_ff;
         busy_next = busy_next | lane_status[k].active_in;
      end
   end

   always_comb begin
      result_new.coils_a    = lane_status[0].coils_in;
      result_new.coils_b    = lane_status[1].coils_in;
      result_new.coils_c    = lane_status[2].coils_in;
      result_new.busy       = busy_next;
      result_new.rejected   = is_motion && busy_now;
      result_new.position_a = position_next[0];
      result_new.position_b = position_next[1];
   end

   // ---------------------------------------------------------------
   // Output register with one skid entry. Stall input only when the
   // skid entry is full; refill the output register from skid first.
   // ---------------------------------------------------------------
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            out_in       = result_new;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result_new;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload holds, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coils_a    = out_ff.coils_a;
   assign rsp_coils_b    = out_ff.coils_b;
   assign rsp_coils_c    = out_ff.coils_c;
   assign rsp_busy_res   = out_ff.busy;
   assign rsp_rejected   = out_ff.rejected;
   assign rsp_position_a = out_ff.position_a;
   assign rsp_position_b = out_ff.position_b;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // skid entry fills only behind a held output register
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while output register empty");

   // a rejected command leaves the axes running
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> rsp_busy_res)
      else $error("rejected result without busy");

   // idle axes have their coils off
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |->
         (rsp_coils_a == '0 && rsp_coils_b == '0 && rsp_coils_c == '0))
      else $error("coils energized while idle");

   // a waiting skid entry is neither lost nor overwritten
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost or overwritten");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for three_axis_stepper_sequencer_unit: directed and random command
// streams, with a transfer-level predictor of all three axes and a per-field result check.
// Depends on tssu_pkg and the top level of the design only.
`timescale 1ns / 1ps

module testbench;
   import tssu_pkg::*;

   localparam int POS_W = POSITION_WIDTH_DEFAULT;

   // command 3 has no meaning in the block; name it for the stimulus
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]      command;
      logic [STEPS_W-1:0]    steps_a, steps_b, steps_c;
      logic [INTERVAL_W-1:0] interval_a, interval_b, interval_c;
   } request_type;

   typedef struct packed {
      logic [COIL_W-1:0] coils_a, coils_b, coils_c;
      logic              busy;
      logic              rejected;
      logic [POS_W-1:0]  position_a, position_b;
   } drive_state_type;

   // clock and the one reset at the start of the run
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // every input starts at a known value
   logic                  req_valid = 1'b0;
   logic [CMD_W-1:0]      req_command = CMD_TICK;
   logic [STEPS_W-1:0]    req_steps_a = '0, req_steps_b = '0, req_steps_c = '0;
   logic [INTERVAL_W-1:0] req_interval_a = '0, req_interval_b = '0, req_interval_c = '0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_valid = 1'b0;
   logic [INTERVAL_W-1:0] csr_home_interval = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic [COIL_W-1:0]     rsp_coils_a, rsp_coils_b, rsp_coils_c;
   logic                  rsp_busy_res;
   logic                  rsp_rejected;
   logic [POS_W-1:0]      rsp_position_a, rsp_position_b;
   logic                  csr_ready;

   three_axis_stepper_sequencer_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_steps_a       (req_steps_a),
      .req_steps_b       (req_steps_b),
      .req_steps_c       (req_steps_c),
      .req_interval_a    (req_interval_a),
      .req_interval_b    (req_interval_b),
      .req_interval_c    (req_interval_c),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_coils_a       (rsp_coils_a),
      .rsp_coils_b       (rsp_coils_b),
      .rsp_coils_c       (rsp_coils_c),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_rejected      (rsp_rejected),
      .rsp_position_a    (rsp_position_a),
      .rsp_position_b    (rsp_position_b),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_home_interval (csr_home_interval)
   );

   // ------------------------------------------------------------------
   // Predictor state: one copy of every axis register plus the home
   // interval, updated once per accepted input transfer.
   // ------------------------------------------------------------------
   logic [PHASE_W-1:0]    coil_phase  [3];
   logic [STEPS_W-1:0]    steps_owed  [3];   // steps still to take after the current one
   logic                  reverse     [3];
   logic [INTERVAL_W-1:0] hold_count  [3];
   logic [INTERVAL_W-1:0] hold_reload [3];
   logic                  running     [3];
   logic [COIL_W-1:0]     coil_bits   [3];
   logic [POS_W-1:0]      step_pos    [2];
   logic [INTERVAL_W-1:0] home_ticks;

   drive_state_type expected_drive[$];   // predicted results, oldest first
   int              errors = 0;
   int              items_sent = 0;

   // idling controls shared by the sender, the receiver and the tests
   logic sender_gaps = 1'b1;
   logic receiver_stalls = 1'b1;
   int   burst_left = 0;
   int   hold_off_left = 0;

   // Two adjacent coils on; the pattern repeats every four phases.
   function automatic logic [COIL_W-1:0] coils_for_phase(input logic [PHASE_W-1:0] p);
      case (p[1:0])
         2'd0:    return 4'b0011;
         2'd1:    return 4'b0110;
         2'd2:    return 4'b1100;
         default: return 4'b1001;
      endcase
   endfunction

   // Move one phase up or down; the 3-bit phase wraps modulo eight on its own.
   function automatic void advance_phase(input int k);
      coil_phase[k] = reverse[k] ? coil_phase[k] - 3'd1 : coil_phase[k] + 3'd1;
      coil_bits[k]  = coils_for_phase(coil_phase[k]);
   endfunction

   function automatic logic any_running();
      return running[0] | running[1] | running[2];
   endfunction

   // Start one axis: position takes the whole count at once, the first step
   // is taken right away, and a count of zero parks the axis with coils off.
   function automatic void launch_axis(input int k, input logic [STEPS_W-1:0] s,
                                       input logic [INTERVAL_W-1:0] iv);
      logic [STEPS_W-1:0]    count;
      logic [INTERVAL_W-1:0] period;
      count  = s[STEPS_W-1] ? (32'd0 - s) : s;
      period = (iv == '0) ? 24'd1 : iv;
      if (k < 2)
         step_pos[k] = step_pos[k] + {{(POS_W - STEPS_W){s[STEPS_W-1]}}, s};
      reverse[k]     = s[STEPS_W-1];
      hold_reload[k] = period;
      if (count == '0) begin
         coil_bits[k]  = '0;
         running[k]    = 1'b0;
         steps_owed[k] = '0;
         hold_count[k] = '0;
      end else begin
         advance_phase(k);
         steps_owed[k] = count - 32'd1;
         hold_count[k] = period;
         running[k]    = 1'b1;
      end
   endfunction

   // Steps that bring a position back to zero, clamped to the 32-bit signed range.
   function automatic logic [STEPS_W-1:0] home_target(input logic [POS_W-1:0] pos);
      logic signed [POS_W-1:0] span48;
      longint                  span;
      span48 = '0 - $signed(pos);
      span   = span48;
      if (span > longint'(STEPS_MAX))
         return STEPS_MAX;
      if (span < -longint'(STEPS_MIN))
         return STEPS_MIN;
      return span[STEPS_W-1:0];
   endfunction

   // Apply one accepted transfer to the predictor and return the result it causes.
   function automatic drive_state_type apply_command(input request_type item);
      drive_state_type       r;
      logic [STEPS_W-1:0]    cnt [3];
      logic [INTERVAL_W-1:0] per [3];
      int                    k;
      r = '0;
      case (item.command)
         CMD_TICK: begin
            for (k = 0; k < 3; k++) begin
               if (running[k]) begin
                  if (hold_count[k] != '0)
                     hold_count[k] = hold_count[k] - 24'd1;
                  if (hold_count[k] == '0) begin
                     if (steps_owed[k] != '0) begin
                        advance_phase(k);
                        steps_owed[k] = steps_owed[k] - 32'd1;
                        hold_count[k] = hold_reload[k];
                     end else begin
                        coil_bits[k] = '0;
                        running[k]   = 1'b0;
                     end
                  end
               end
            end
         end
         CMD_MOVE, CMD_HOME: begin
            if (any_running()) begin
               r.rejected = 1'b1;
            end else begin
               if (item.command == CMD_MOVE) begin
                  cnt[0] = item.steps_a;    cnt[1] = item.steps_b;    cnt[2] = item.steps_c;
                  per[0] = item.interval_a; per[1] = item.interval_b; per[2] = item.interval_c;
               end else begin
                  cnt[0] = home_target(step_pos[0]);
                  cnt[1] = home_target(step_pos[1]);
                  cnt[2] = '0;
                  per[0] = home_ticks; per[1] = home_ticks; per[2] = home_ticks;
               end
               for (k = 0; k < 3; k++)
                  launch_axis(k, cnt[k], per[k]);
            end
         end
         default: ;   // the unused code leaves everything as it is
      endcase
      r.coils_a    = coil_bits[0];
      r.coils_b    = coil_bits[1];
      r.coils_c    = coil_bits[2];
      r.busy       = any_running();
      r.position_a = step_pos[0];
      r.position_b = step_pos[1];
      return r;
   endfunction

   // Ticks a home command would cost from here; used to keep homes affordable.
   function automatic longint home_cost();
      longint pa, pb, reach;
      pa    = $signed(step_pos[0]);
      pb    = $signed(step_pos[1]);
      pa    = (pa < 0) ? -pa : pa;
      pb    = (pb < 0) ? -pb : pb;
      reach = (pa > pb) ? pa : pb;
      return reach * longint'((home_ticks == '0) ? 24'd1 : home_ticks);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic request_type random_request(input logic [CMD_W-1:0] cmd);
      request_type item;
      item.command    = cmd;
      item.steps_a    = $urandom;
      item.steps_b    = $urandom;
      item.steps_c    = $urandom;
      item.interval_a = INTERVAL_W'($urandom);
      item.interval_b = INTERVAL_W'($urandom);
      item.interval_c = INTERVAL_W'($urandom);
      return item;
   endfunction

   // Mostly short moves, now and then a longer one, sometimes zero; either direction.
   function automatic logic [STEPS_W-1:0] pick_count();
      int                 r;
      logic [STEPS_W-1:0] c;
      r = $urandom_range(0, 11);
      if (r == 0)
         c = '0;
      else if (r == 11)
         c = $urandom_range(5, 20);
      else
         c = $urandom_range(1, 4);
      if ($urandom_range(0, 1))
         c = 32'd0 - c;
      return c;
   endfunction

   // Short intervals keep sequences quick; zero shows up to exercise its use as one.
   function automatic logic [INTERVAL_W-1:0] pick_interval();
      int r;
      r = $urandom_range(0, 11);
      if (r == 0)
         return '0;
      if (r == 11)
         return INTERVAL_W'($urandom_range(4, 30));
      return INTERVAL_W'($urandom_range(1, 3));
   endfunction

   function automatic request_type move_request(input logic [STEPS_W-1:0] sa, sb, sc,
                                                input logic [INTERVAL_W-1:0] ia, ib, ic);
      request_type item;
      item = '{command: CMD_MOVE, steps_a: sa, steps_b: sb, steps_c: sc,
               interval_a: ia, interval_b: ib, interval_c: ic};
      return item;
   endfunction

   // Offer one item and hold it until the transfer; predict on acceptance,
   // then, with sender gaps on, drop valid for a random gap at the end of each burst.
   task automatic send_item(input request_type item);
      drive_state_type want;
      req_command    <= item.command;
      req_steps_a    <= item.steps_a;
      req_steps_b    <= item.steps_b;
      req_steps_c    <= item.steps_c;
      req_interval_a <= item.interval_a;
      req_interval_b <= item.interval_b;
      req_interval_c <= item.interval_c;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      want = apply_command(item);
      expected_drive.push_back(want);
      items_sent++;
      if (sender_gaps) begin
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Feed ticks until every axis has finished its move.
   task automatic run_out_axes();
      while (any_running())
         send_item(random_request(CMD_TICK));
   endtask

   // Drop valid, wait for every outstanding result, then let the output
   // buffer settle.
   task automatic settle_outputs();
      req_valid <= 1'b0;
      while (expected_drive.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the home interval while the block is quiet.
   task automatic program_home_interval(input logic [INTERVAL_W-1:0] value);
      settle_outputs();
      csr_home_interval <= value;
      csr_valid         <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid  <= 1'b0;
      home_ticks = value;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Short hand-picked stream: idle commands, rejection while busy, phase
   // wrap in both directions, zero intervals and extreme field values.
   task automatic test_directed();
      request_type item;
      // home from position zero: nothing to do, axes stay idle
      send_item(random_request(CMD_HOME));
      // unused command with every payload bit set: no effect, not rejected
      item = '1;
      item.command = CMD_UNUSED;
      send_item(item);
      // all-zero counts: every axis stays off
      send_item(move_request('0, '0, '0, '0, '0, '0));
      // one step up, one step down, two steps with a two-tick interval
      send_item(move_request(32'd1, 32'hFFFF_FFFF, 32'd2, '0, 24'd1, 24'd2));
      // while busy: move with extreme payload, home and unused code
      send_item(move_request(STEPS_MIN, STEPS_MAX, '1, '1, '1, '1));
      send_item(move_request('0, '0, '0, '0, '0, '0) ^ {CMD_HOME ^ CMD_MOVE, 168'd0});
      item = '0;
      item.command = CMD_UNUSED;
      send_item(item);
      run_out_axes();
      // tick with nothing running
      send_item(random_request(CMD_TICK));
      // axis a down across phase zero, b up across seven, c down three
      send_item(move_request(32'hFFFF_FFFE, 32'd1, 32'hFFFF_FFFD, 24'd1, 24'd3, '0));
      run_out_axes();
   endtask

   // Home from one step away under a short programmed interval, so the
   // run-out stays a handful of ticks.
   task automatic test_home_one_step();
      program_home_interval(24'd4);
      send_item(random_request(CMD_HOME));
      run_out_axes();
   endtask

   // Home interval at zero (behaves as one) and at its maximum.
   task automatic test_home_interval_extremes();
      program_home_interval('0);
      send_item(move_request(32'd3, 32'hFFFF_FFFE, '0, 24'd1, 24'd1, 24'd1));
      run_out_axes();
      send_item(random_request(CMD_HOME));
      run_out_axes();
      program_home_interval('1);
      // positions are back at zero, so home takes no steps at all
      send_item(random_request(CMD_HOME));
      send_item(random_request(CMD_TICK));
   endtask

   // Mostly well-formed sequences: a move or an affordable home, ticks until
   // idle, with rejected commands and unused codes mixed in as noise.
   task automatic test_random_sequences(input int count);
      request_type item;
      int          stop_at;
      int          pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         item = random_request(CMD_TICK);
         if (!any_running()) begin
            if (pick < 15 && home_cost() <= 300)
               item.command = CMD_HOME;
            else if (pick < 85)
               item = move_request(pick_count(), pick_count(), pick_count(),
                                   pick_interval(), pick_interval(), pick_interval());
            else if (pick < 92)
               item.command = CMD_UNUSED;
         end else begin
            if (pick < 6)
               item.command = CMD_MOVE;
            else if (pick < 10)
               item.command = CMD_HOME;
            else if (pick < 13)
               item.command = CMD_UNUSED;
         end
         send_item(item);
      end
   endtask

   // Hold the result side off for a long stretch while the sender keeps
   // offering back to back, so the output buffer fills and stalls the input.
   task automatic test_backpressure();
      sender_gaps   = 1'b0;
      hold_off_left = 60;
      test_random_sequences(40);
   endtask

   // ------------------------------------------------------------------
   // Result side: stall pattern and the checker
   // ------------------------------------------------------------------
   initial begin : stall_pattern
      int   run;
      logic level;
      run   = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else if (!receiver_stalls) begin
            rsp_stall <= 1'b0;
         end else begin
            // alternate runs: short stalls, longer open windows
            if (run <= 0) begin
               level = !level;
               run   = level ? $urandom_range(1, 6) : $urandom_range(1, 24);
            end
            rsp_stall <= level;
            run--;
         end
      end
   end

   task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                                input logic [POS_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : drive_check
      drive_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drive.size() == 0) begin
            errors++;
            $display("%0t ns: result transfer with none expected, expected none, actual %h",
                     $time, {rsp_coils_a, rsp_coils_b, rsp_coils_c, rsp_busy_res,
                             rsp_rejected, rsp_position_a, rsp_position_b});
         end else begin
            want = expected_drive.pop_front();
            compare_field("coils_a",    POS_W'(want.coils_a),  POS_W'(rsp_coils_a));
            compare_field("coils_b",    POS_W'(want.coils_b),  POS_W'(rsp_coils_b));
            compare_field("coils_c",    POS_W'(want.coils_c),  POS_W'(rsp_coils_c));
            compare_field("busy_res",   POS_W'(want.busy),     POS_W'(rsp_busy_res));
            compare_field("rejected",   POS_W'(want.rejected), POS_W'(rsp_rejected));
            compare_field("position_a", want.position_a, rsp_position_a);
            compare_field("position_b", want.position_b, rsp_position_b);
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_sequence
      int k;
      for (k = 0; k < 3; k++) begin
         coil_phase[k]  = '0;
         steps_owed[k]  = '0;
         reverse[k]     = 1'b0;
         hold_count[k]  = '0;
         hold_reload[k] = '0;
         running[k]     = 1'b0;
         coil_bits[k]   = '0;
      end
      step_pos[0] = '0;
      step_pos[1] = '0;
      home_ticks  = HOME_INTERVAL_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_home_one_step();
      test_home_interval_extremes();

      // random phases, each under its own home interval and idling mix
      sender_gaps = 1'b1; receiver_stalls = 1'b1;
      program_home_interval(24'd1);
      test_random_sequences(160);

      sender_gaps = 1'b0; receiver_stalls = 1'b0;
      program_home_interval(24'd2);
      test_random_sequences(150);
      test_backpressure();

      sender_gaps = 1'b1; receiver_stalls = 1'b0;
      program_home_interval(INTERVAL_W'($urandom_range(3, 7)));
      test_random_sequences(150);

      sender_gaps = 1'b0; receiver_stalls = 1'b1;
      program_home_interval(24'd5);
      test_random_sequences(150);

      // drain everything still in flight and let the block settle
      settle_outputs();
      if (errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : run_limit
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/tssu_pkg.sv
design/tssu_axis_lane.sv
design/tssu_position.sv
design/three_axis_stepper_sequencer_unit.sv
bench/testbench.sv
